// File: rtl/core/tgarle_pkg.sv
// Shared types and constants for the TGA run-length pixel decoder.
package tgarle_pkg;

   localparam int PIXEL_COUNT_BITS = 24;
   localparam int PIXEL_COUNT_W    = 25;
   localparam int BPP_W            = 3;
   localparam int CSR_INDEX_W      = 2;
   localparam int CSR_DATA_W       = 25;
   localparam int CNT_CMP_W        = (PIXEL_COUNT_BITS + 1 > PIXEL_COUNT_W) ?
                                     PIXEL_COUNT_BITS + 1 : PIXEL_COUNT_W;

   localparam logic [BPP_W-1:0]         BPP_RESET         = BPP_W'(4);
   localparam logic [PIXEL_COUNT_W-1:0] PIXEL_COUNT_RESET = PIXEL_COUNT_W'(65536);
   localparam logic [7:0]               RUN_FLAG_MASK     = 8'h80;
   localparam logic [7:0]               RUN_LEN_MASK      = 8'h7F;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BYTES_PER_PIXEL = 2'd0,
      CSR_PIXEL_COUNT     = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_PIXEL   = 2'd0,
      STATUS_NONE    = 2'd1,
      STATUS_REFUSED = 2'd2,
      STATUS_IDLE    = 2'd3
   } status_type;

   typedef enum logic {
      OP_BYTE  = 1'b0,
      OP_DRAIN = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      PH_HEADER      = 4'b0001,
      PH_LITERAL     = 4'b0010,
      PH_RUN_FILL    = 4'b0100,
      PH_RUN_PENDING = 4'b1000
   } phase_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic                   we;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  wdata;
   } csr_write_type;

   typedef struct packed {
      status_type status;
      logic [7:0] pixel_b0;
      logic [7:0] pixel_b1;
      logic [7:0] pixel_b2;
      logic [7:0] pixel_b3;
      logic       image_done;
   } result_type;

endpackage

// File: rtl/core/tgarle_ifs.sv
// Request and response channel interfaces of the TGA run-length pixel decoder.
interface tgarle_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] data_byte;

   modport source (output valid, output req_type, output data_byte, input ready);
   modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface tgarle_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] pixel_b0;
   logic [7:0] pixel_b1;
   logic [7:0] pixel_b2;
   logic [7:0] pixel_b3;
   logic       image_done;

   modport source (output valid, output status, output pixel_b0, output pixel_b1,
                   output pixel_b2, output pixel_b3, output image_done, input ready);
   modport sink   (input valid, input status, input pixel_b0, input pixel_b1,
                   input pixel_b2, input pixel_b3, input image_done, output ready);
endinterface

// File: rtl/core/tgarle_front.sv
// Front end: accepts request transactions, classifies them and queues them.
module tgarle_front (
   input  logic                clock,
   input  logic                reset,
   tgarle_req_if.sink          req_ch,
   output logic                q_valid,
   output tgarle_pkg::item_type q_item,
   input  logic                q_pop
);
   import tgarle_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   new_item;

   assign req_ch.ready = !reset && (count_ff != 2'd2);
   assign push         = req_ch.valid && req_ch.ready;
   assign new_item.op  = req_ch.req_type ? OP_DRAIN : OP_BYTE;
   assign new_item.data_byte = req_ch.data_byte;

   assign q_valid = (count_ff != 2'd0);
   assign q_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// File: rtl/core/tgarle_back.sv
// Back end: packet state machine, pixel assembly and response register.
module tgarle_back (
   input  logic                      clock,
   input  logic                      reset,
   input  tgarle_pkg::csr_write_type csr,
   input  logic                      q_valid,
   input  tgarle_pkg::item_type      q_item,
   output logic                      q_pop,
   tgarle_rsp_if.source              rsp_ch
);
   import tgarle_pkg::*;

   logic [BPP_W-1:0]            bpp_ff;
   logic [PIXEL_COUNT_W-1:0]    pixel_count_ff;
   phase_type                   phase_ff, phase_in;
   logic [6:0]                  left_ff, left_in;
   logic [1:0]                  bip_ff, bip_in;
   logic [31:0]                 buf_ff, buf_in, buf_upd;
   logic [PIXEL_COUNT_BITS-1:0] written_ff, written_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   result_type                  rsp_ff, res;
   logic                        fire;
   logic                        size4;
   logic                        last_byte;
   logic                        emit_en;
   logic [31:0]                 emit_buf;
   logic [PIXEL_COUNT_BITS:0]   next_count;
   logic                        done;

   assign fire       = q_valid && (!rsp_valid_ff || rsp_ch.ready);
   assign q_pop      = fire;
   assign size4      = (bpp_ff == BPP_W'(4));
   assign last_byte  = ({1'b0, bip_ff} + 3'd1) >= (size4 ? 3'd4 : 3'd3);
   assign next_count = {1'b0, written_ff} + (PIXEL_COUNT_BITS+1)'(1);
   assign done       = CNT_CMP_W'(next_count) >= CNT_CMP_W'(pixel_count_ff);

   always_comb begin
      buf_upd = buf_ff;
      buf_upd[{bip_ff, 3'b000} +: 8] = q_item.data_byte;
   end

   always_comb begin
      phase_in   = phase_ff;
      left_in    = left_ff;
      bip_in     = bip_ff;
      buf_in     = buf_ff;
      written_in = written_ff;
      emit_en    = 1'b0;
      emit_buf   = buf_ff;
      res        = '0;
      res.status = STATUS_IDLE;
      if (fire) begin
         unique case (q_item.op)
            OP_DRAIN: begin
               if (phase_ff == PH_RUN_PENDING) begin
                  emit_en = 1'b1;
               end
            end
            OP_BYTE: begin
               unique case (phase_ff)
                  PH_RUN_PENDING: res.status = STATUS_REFUSED;
                  PH_HEADER: begin
                     left_in    = q_item.data_byte[6:0] & RUN_LEN_MASK[6:0];
                     bip_in     = 2'd0;
                     buf_in     = '0;
                     phase_in   = ((q_item.data_byte & RUN_FLAG_MASK) != 8'd0) ?
                                  PH_RUN_FILL : PH_LITERAL;
                     res.status = STATUS_NONE;
                  end
                  PH_LITERAL, PH_RUN_FILL: begin
                     buf_in     = buf_upd;
                     res.status = STATUS_NONE;
                     if (last_byte) begin
                        bip_in = 2'd0;
                        if (phase_ff == PH_LITERAL) begin
                           emit_en  = 1'b1;
                           emit_buf = buf_upd;
                        end else begin
                           phase_in = PH_RUN_PENDING;
                        end
                     end else begin
                        bip_in = bip_ff + 2'd1;
                     end
                  end
                  default: phase_in = PH_HEADER;
               endcase
            end
            default: phase_in = PH_HEADER;
         endcase
      end
      if (emit_en) begin
         res.status     = STATUS_PIXEL;
         res.pixel_b0   = emit_buf[7:0];
         res.pixel_b1   = emit_buf[15:8];
         res.pixel_b2   = emit_buf[23:16];
         res.pixel_b3   = size4 ? emit_buf[31:24] : 8'd0;
         res.image_done = done;
         if (done) begin
            written_in = '0;
            phase_in   = PH_HEADER;
            left_in    = 7'd0;
         end else begin
            written_in = next_count[PIXEL_COUNT_BITS-1:0];
            if (left_ff == 7'd0) begin
               phase_in = PH_HEADER;
            end else begin
               left_in = left_ff - 7'd1;
            end
         end
      end
   end

   always_comb begin
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff         <= BPP_RESET;
         pixel_count_ff <= PIXEL_COUNT_RESET;
         phase_ff       <= PH_HEADER;
         left_ff        <= 7'd0;
         bip_ff         <= 2'd0;
         buf_ff         <= '0;
         written_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr.we) begin
            unique case (csr.index)
               CSR_BYTES_PER_PIXEL: bpp_ff         <= csr.wdata[BPP_W-1:0];
               CSR_PIXEL_COUNT:     pixel_count_ff <= csr.wdata[PIXEL_COUNT_W-1:0];
               default: ;
            endcase
         end
         phase_ff     <= phase_in;
         left_ff      <= left_in;
         bip_ff       <= bip_in;
         buf_ff       <= buf_in;
         written_ff   <= written_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= res;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_ff.status;
   assign rsp_ch.pixel_b0   = rsp_ff.pixel_b0;
   assign rsp_ch.pixel_b1   = rsp_ff.pixel_b1;
   assign rsp_ch.pixel_b2   = rsp_ff.pixel_b2;
   assign rsp_ch.pixel_b3   = rsp_ff.pixel_b3;
   assign rsp_ch.image_done = rsp_ff.image_done;

endmodule

// File: rtl/core/tga_rle_pixel_decoder.sv
// Top level of the TGA run-length pixel decoder.
//
//   channel   direction  handshake      payload
//   req_ch    in         valid/ready    req_type, data_byte
//   rsp_ch    out        valid/ready    status, pixel_b0..pixel_b3, image_done
//   csr_*     in         write enable   csr_index, csr_wdata
//
// One response per request transaction; one transaction per cycle sustained
// while rsp_ch is not stalled. A request is held in the two-entry queue and
// then in the response register before its response is valid.
// Reset is synchronous. The queue and response register let either side
// stall without blocking the other until the queue fills.
module tga_rle_pixel_decoder (
   input  logic                                clock,
   input  logic                                reset,
   tgarle_req_if.sink                          req_ch,
   tgarle_rsp_if.source                        rsp_ch,
   input  logic                                csr_we,
   input  logic [tgarle_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tgarle_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tgarle_pkg::*;

   csr_write_type csr;
   logic          q_valid;
   item_type      q_item;
   logic          q_pop;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   tgarle_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   tgarle_back u_back (
      .clock   (clock),
      .reset   (reset),
      .csr     (csr),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule
